// ===== rtl/tgad_pkg.sv =====
`timescale 1ns / 1ps

package tgad_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_IDSKIP,
      PH_PACKET,
      PH_PIXEL,
      PH_IDLE
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_HEADER    = 2'd0;
   localparam logic [1:0] KIND_PIXEL     = 2'd1;
   localparam logic [1:0] KIND_BAD_TYPE  = 2'd2;
   localparam logic [1:0] KIND_BAD_DEPTH = 2'd3;

   // header layout
   localparam int          HDR_COUNT_W   = 5;
   localparam logic [4:0]  HDR_ID_LEN    = 5'd0;
   localparam logic [4:0]  HDR_CMAP      = 5'd1;
   localparam logic [4:0]  HDR_TYPE      = 5'd2;
   localparam logic [4:0]  HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0]  HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0]  HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0]  HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0]  HDR_DEPTH     = 5'd16;
   localparam logic [4:0]  HDR_LAST      = 5'd17;

   localparam logic [7:0]  TYPE_RAW      = 8'd2;
   localparam logic [7:0]  TYPE_RLE      = 8'd10;
   localparam logic [7:0]  DEPTH_24      = 8'd24;
   localparam logic [7:0]  DEPTH_32      = 8'd32;
   localparam logic [7:0]  ALPHA_OPAQUE  = 8'hff;
   localparam logic [7:0]  PKT_COUNT_MASK = 8'h7f;

   // divider for run wrap: quotient is at most the longest run
   localparam int DIM_W         = 16;
   localparam int RUN_W         = 8;
   localparam int DIV_QUOT_W    = 9;
   localparam int DIV_BITS_STEP = 3;
   localparam int DIV_CYCLES    = DIV_QUOT_W / DIV_BITS_STEP;
   localparam int DIV_NUM_W     = DIM_W + 1;
   localparam int DIV_DVS_W     = DIM_W + DIV_QUOT_W - 1;

   typedef struct packed {
      logic                   start;
      logic [DIV_NUM_W-1:0]   dividend;
      logic [DIM_W-1:0]       divisor;
   } div_start_type;

   typedef struct packed {
      logic                   valid;
      logic [DIV_QUOT_W-1:0]  quot;
      logic [DIM_W-1:0]       rem;
   } div_result_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        alpha;
      logic [DIM_W-1:0]  start_row;
      logic [DIM_W-1:0]  start_column;
      logic [RUN_W-1:0]  run_length;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
      logic              image_done;
   } rsp_item_type;

endpackage

// ===== rtl/tgad_div.sv =====
`timescale 1ns / 1ps

module tgad_div
   import tgad_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  div_start_type  start_i,
   output div_result_type result_o
);

   localparam int STEPS_W = $clog2(DIV_CYCLES + 1);

   logic [DIV_NUM_W-1:0]  rem_ff, rem_in;
   logic [DIV_DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_QUOT_W-1:0] quot_ff, quot_in;
   logic [STEPS_W-1:0]    steps_ff;

   // restoring division, a few quotient bits per cycle
   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      for (int j = 0; j < DIV_BITS_STEP; j++) begin
         if ({{(DIV_DVS_W-DIV_NUM_W){1'b0}}, rem_in} >= dvs_in) begin
            rem_in  = rem_in - dvs_in[DIV_NUM_W-1:0];
            quot_in = {quot_in[DIV_QUOT_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_in[DIV_QUOT_W-2:0], 1'b0};
         end
         dvs_in = dvs_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else if (start_i.start) begin
         steps_ff <= STEPS_W'(DIV_CYCLES);
      end else if (steps_ff != '0) begin
         steps_ff <= steps_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start_i.start) begin
         rem_ff  <= start_i.dividend;
         dvs_ff  <= {start_i.divisor, {(DIV_QUOT_W-1){1'b0}}};
         quot_ff <= '0;
      end else if (steps_ff != '0) begin
         rem_ff  <= rem_in;
         dvs_ff  <= dvs_in;
         quot_ff <= quot_in;
      end
   end

   // final bits are handed over on the edge of the last step
   assign result_o.valid = (steps_ff == STEPS_W'(1));
   assign result_o.quot  = quot_in;
   assign result_o.rem   = rem_in[DIM_W-1:0];

endmodule

// ===== rtl/tgad_parser.sv =====
`timescale 1ns / 1ps

module tgad_parser
   import tgad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept_i,
   input  logic [7:0]    data_byte_i,
   input  logic          file_start_i,
   output logic          res_valid_o,
   output rsp_item_type  res_o
);

   phase_type               phase_ff, phase_in;
   logic [HDR_COUNT_W-1:0]  hcount_ff, hcount_in;
   logic [7:0]              idskip_ff, idskip_in;
   logic                    rle_ff, rle_in;
   logic                    bpp4_ff, bpp4_in;
   logic [DIM_W-1:0]        width_ff, width_in;
   logic [DIM_W-1:0]        height_ff, height_in;
   logic [DIM_W-1:0]        row_ff, row_in;
   logic [DIM_W-1:0]        col_ff, col_in;
   logic [RUN_W-1:0]        pkt_left_ff, pkt_left_in;
   logic                    pkt_run_ff, pkt_run_in;
   logic [1:0]              idx_ff, idx_in;
   logic [7:0]              cmap_ff, cmap_in;
   logic [7:0]              type_ff, type_in;
   logic [7:0]              depth_ff, depth_in;
   logic [2*DIM_W-1:0]      left_ff, left_in;
   logic [2*DIM_W-1:0]      area_ff;
   logic [7:0]              byte0_ff, byte0_in;
   logic [7:0]              byte1_ff, byte1_in;
   logic [7:0]              byte2_ff, byte2_in;

   phase_type               eff_phase;
   logic [HDR_COUNT_W-1:0]  eff_count;
   logic                    begin_px;
   logic                    rle_new;
   logic                    complete;
   logic [RUN_W-1:0]        run_len;
   logic                    clip;
   logic                    done;

   div_start_type           div_start;
   div_result_type          div_res;

   tgad_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start_i  (div_start),
      .result_o (div_res)
   );

   always_comb begin
      phase_in    = phase_ff;
      hcount_in   = hcount_ff;
      idskip_in   = idskip_ff;
      rle_in      = rle_ff;
      bpp4_in     = bpp4_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      pkt_left_in = pkt_left_ff;
      pkt_run_in  = pkt_run_ff;
      idx_in      = idx_ff;
      cmap_in     = cmap_ff;
      type_in     = type_ff;
      depth_in    = depth_ff;
      left_in     = left_ff;
      byte0_in    = byte0_ff;
      byte1_in    = byte1_ff;
      byte2_in    = byte2_ff;
      begin_px    = 1'b0;
      rle_new     = rle_ff;
      complete    = 1'b0;
      run_len     = '0;
      clip        = 1'b0;
      done        = 1'b0;
      res_valid_o = 1'b0;
      res_o       = '0;
      div_start.start    = 1'b0;
      div_start.dividend = {1'b0, col_ff};
      div_start.divisor  = width_ff;

      // long run wrapped over rows: position lands from the divider
      if (div_res.valid) begin
         col_in = div_res.rem;
         row_in = row_ff - DIM_W'(div_res.quot);
      end

      eff_phase = file_start_i ? PH_HEADER : phase_ff;
      eff_count = file_start_i ? '0 : hcount_ff;

      if (accept_i) begin
         unique case (eff_phase)
            PH_HEADER: begin
               case (eff_count)
                  HDR_ID_LEN:    idskip_in = data_byte_i;
                  HDR_CMAP:      cmap_in = data_byte_i;
                  HDR_TYPE:      type_in = data_byte_i;
                  HDR_WIDTH_LO:  width_in[7:0] = data_byte_i;
                  HDR_WIDTH_HI:  width_in[15:8] = data_byte_i;
                  HDR_HEIGHT_LO: height_in[7:0] = data_byte_i;
                  HDR_HEIGHT_HI: height_in[15:8] = data_byte_i;
                  HDR_DEPTH:     depth_in = data_byte_i;
                  default: ;
               endcase
               hcount_in = eff_count + 1'b1;
               phase_in  = PH_HEADER;
               if (eff_count == HDR_LAST) begin
                  hcount_in   = '0;
                  res_valid_o = 1'b1;
                  phase_in    = PH_IDLE;
                  if (type_ff != TYPE_RAW && type_ff != TYPE_RLE) begin
                     res_o.kind = KIND_BAD_TYPE;
                  end else if (cmap_ff != 8'd0 ||
                               (depth_ff != DEPTH_24 && depth_ff != DEPTH_32)) begin
                     res_o.kind = KIND_BAD_DEPTH;
                  end else begin
                     rle_new            = (type_ff == TYPE_RLE);
                     rle_in             = rle_new;
                     bpp4_in            = (depth_ff == DEPTH_32);
                     res_o.kind         = KIND_HEADER;
                     res_o.image_width  = width_ff;
                     res_o.image_height = height_ff;
                     if (width_ff == '0 || height_ff == '0) begin
                        res_o.image_done = 1'b1;
                     end else if (idskip_ff != 8'd0) begin
                        phase_in = PH_IDSKIP;
                     end else begin
                        begin_px = 1'b1;
                     end
                  end
               end
            end
            PH_IDSKIP: begin
               idskip_in = idskip_ff - 1'b1;
               if (idskip_in == 8'd0) begin
                  begin_px = 1'b1;
               end
            end
            PH_PACKET: begin
               pkt_left_in = (data_byte_i & PKT_COUNT_MASK) + 1'b1;
               pkt_run_in  = data_byte_i[7];
               idx_in      = '0;
               phase_in    = PH_PIXEL;
            end
            PH_PIXEL: begin
               complete = (idx_ff == 2'd3) || (!bpp4_ff && idx_ff == 2'd2);
               idx_in   = idx_ff + 1'b1;
               case (idx_ff)
                  2'd0: byte0_in = data_byte_i;
                  2'd1: byte1_in = data_byte_i;
                  2'd2: byte2_in = data_byte_i;
                  default: ;
               endcase
               if (complete) begin
                  idx_in  = '0;
                  run_len = pkt_run_ff ? pkt_left_ff : RUN_W'(1);
                  clip    = (left_ff[2*DIM_W-1:RUN_W] == '0) && (left_ff[RUN_W-1:0] < run_len);
                  if (clip) begin
                     run_len = left_ff[RUN_W-1:0];
                  end
                  done = ({{(2*DIM_W-RUN_W){1'b0}}, run_len} == left_ff);

                  res_valid_o        = 1'b1;
                  res_o.kind         = KIND_PIXEL;
                  res_o.blue         = byte0_ff;
                  res_o.green        = byte1_ff;
                  res_o.red          = (idx_ff == 2'd2) ? data_byte_i : byte2_ff;
                  res_o.alpha        = bpp4_ff ? data_byte_i : ALPHA_OPAQUE;
                  res_o.start_row    = row_ff;
                  res_o.start_column = col_ff;
                  res_o.run_length   = run_len;
                  res_o.image_width  = width_ff;
                  res_o.image_height = height_ff;
                  res_o.image_done   = done;

                  if (done) begin
                     phase_in = PH_IDLE;
                  end else begin
                     left_in = left_ff - {{(2*DIM_W-RUN_W){1'b0}}, run_len};
                     if (run_len == RUN_W'(1)) begin
                        // single pixel steps at most one row
                        if (col_ff + 1'b1 == width_ff) begin
                           col_in = '0;
                           row_in = row_ff - 1'b1;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end else begin
                        div_start.start    = 1'b1;
                        div_start.dividend = {1'b0, col_ff}
                                             + {{(DIV_NUM_W-RUN_W){1'b0}}, run_len};
                     end
                     if (rle_ff) begin
                        if (pkt_run_ff) begin
                           phase_in = PH_PACKET;
                        end else begin
                           pkt_left_in = pkt_left_ff - 1'b1;
                           if (pkt_left_in == '0) begin
                              phase_in = PH_PACKET;
                           end
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (begin_px) begin
         row_in      = height_ff - 1'b1;
         col_in      = '0;
         idx_in      = '0;
         byte0_in    = '0;
         byte1_in    = '0;
         byte2_in    = '0;
         pkt_left_in = '0;
         pkt_run_in  = 1'b0;
         left_in     = area_ff;
         phase_in    = rle_new ? PH_PACKET : PH_PIXEL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hcount_ff   <= '0;
         idskip_ff   <= '0;
         rle_ff      <= 1'b0;
         bpp4_ff     <= 1'b0;
         width_ff    <= '0;
         height_ff   <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         pkt_left_ff <= '0;
         pkt_run_ff  <= 1'b0;
         idx_ff      <= '0;
         cmap_ff     <= '0;
         type_ff     <= '0;
         depth_ff    <= '0;
         left_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         hcount_ff   <= hcount_in;
         idskip_ff   <= idskip_in;
         rle_ff      <= rle_in;
         bpp4_ff     <= bpp4_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         pkt_left_ff <= pkt_left_in;
         pkt_run_ff  <= pkt_run_in;
         idx_ff      <= idx_in;
         cmap_ff     <= cmap_in;
         type_ff     <= type_in;
         depth_ff    <= depth_in;
         left_ff     <= left_in;
      end
   end

   // image area is settled by the time the last header byte is taken
   always_ff @(posedge clock) begin
      area_ff  <= width_ff * height_ff;
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
      byte2_ff <= byte2_in;
   end

endmodule

// ===== rtl/tga_rle_rgba_decoder.sv =====
`timescale 1ns / 1ps

// a result is on rsp_tvalid in the cycle after the transfer of the byte that completes it
// throughput: one byte per cycle, held off by rsp back-pressure; one result at most per byte
// the row wrap of a long run is resolved by a divider, done before the next pixel
// reset: synchronous, active high; parser back to header byte zero, result register emptied

module tga_rle_rgba_decoder
   import tgad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // data_byte
   input  logic [0:0]    req_tuser,   // file_start
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // red, green, blue, alpha, start_row, start_column,
                                      // run_length, image_width, image_height
   output logic [1:0]    rsp_tuser,   // result_kind
   output logic          rsp_tlast    // image_done
);

   logic          accept;
   logic          res_valid;
   rsp_item_type  res;
   logic          out_valid_ff;
   rsp_item_type  out_ff;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   tgad_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept_i     (accept),
      .data_byte_i  (req_tdata),
      .file_start_i (req_tuser[0]),
      .res_valid_o  (res_valid),
      .res_o        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_tready) begin
         out_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.image_done;
   assign rsp_tdata  = {out_ff.image_height, out_ff.image_width, out_ff.run_length,
                        out_ff.start_column, out_ff.start_row, out_ff.alpha,
                        out_ff.blue, out_ff.green, out_ff.red};

endmodule

// ===== sim/tga_decode_checker.sv =====
`timescale 1ns / 1ps

module tga_decode_checker
   import tgad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [7:0]    req_tdata,   // data_byte
   input  logic [0:0]    req_tuser,   // file_start
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [103:0]  rsp_tdata,   // red, green, blue, alpha, start_row, start_column,
                                      // run_length, image_width, image_height
   input  logic [1:0]    rsp_tuser,   // result_kind
   input  logic          rsp_tlast,   // image_done
   output int unsigned   pending,
   output int            failures
);

   // decoder state as seen from the byte stream
   phase_type        phase;
   logic [4:0]       hdr_idx;
   logic [7:0]       id_left;
   logic             rle_mode;
   logic [2:0]       pix_bytes;
   logic [15:0]      img_w;
   logic [15:0]      img_h;
   logic [15:0]      row_pos;
   logic [15:0]      col_pos;
   logic [7:0]       pkt_left;
   logic             pkt_run;
   logic [31:0]      color_acc;
   logic [1:0]       color_idx;
   logic [7:0]       cmap_byte;
   logic [7:0]       type_byte;
   logic [7:0]       depth_byte;

   rsp_item_type     decoded_q[$];

   function automatic void clear_decoder();
      phase = PH_HEADER;
      hdr_idx = '0;
      id_left = '0;
      rle_mode = 1'b0;
      pix_bytes = 3'd3;
      img_w = '0;
      img_h = '0;
      row_pos = '0;
      col_pos = '0;
      pkt_left = '0;
      pkt_run = 1'b0;
      color_acc = '0;
      color_idx = '0;
      cmap_byte = '0;
      type_byte = '0;
      depth_byte = '0;
   endfunction

   // rows are written bottom-up, so the first pixel lands on the top index
   function automatic void start_image();
      row_pos = img_h - 16'd1;
      col_pos = '0;
      color_idx = '0;
      color_acc = '0;
      pkt_left = '0;
      pkt_run = 1'b0;
      phase = rle_mode ? PH_PACKET : PH_PIXEL;
   endfunction

   function automatic bit header_step(input logic [7:0] b, output rsp_item_type res);
      res = '0;
      case (hdr_idx)
         HDR_ID_LEN:    id_left = b;
         HDR_CMAP:      cmap_byte = b;
         HDR_TYPE:      type_byte = b;
         HDR_WIDTH_LO:  img_w[7:0] = b;
         HDR_WIDTH_HI:  img_w[15:8] = b;
         HDR_HEIGHT_LO: img_h[7:0] = b;
         HDR_HEIGHT_HI: img_h[15:8] = b;
         HDR_DEPTH:     depth_byte = b;
         default: ;
      endcase
      if (hdr_idx != HDR_LAST) begin
         hdr_idx = hdr_idx + 5'd1;
         return 1'b0;
      end
      hdr_idx = '0;
      if (type_byte != TYPE_RAW && type_byte != TYPE_RLE) begin
         phase = PH_IDLE;
         res.kind = KIND_BAD_TYPE;
         return 1'b1;
      end
      if (cmap_byte != 8'd0 || (depth_byte != DEPTH_24 && depth_byte != DEPTH_32)) begin
         phase = PH_IDLE;
         res.kind = KIND_BAD_DEPTH;
         return 1'b1;
      end
      rle_mode = (type_byte == TYPE_RLE);
      pix_bytes = depth_byte[5:3];
      res.kind = KIND_HEADER;
      res.image_width = img_w;
      res.image_height = img_h;
      if (img_w == 16'd0 || img_h == 16'd0) begin
         phase = PH_IDLE;
         res.image_done = 1'b1;
         return 1'b1;
      end
      if (id_left != 8'd0)
         phase = PH_IDSKIP;
      else
         start_image();
      return 1'b1;
   endfunction

   function automatic bit pixel_step(input logic [7:0] b, output rsp_item_type res);
      logic [31:0] remaining;
      logic [31:0] span;
      logic [31:0] col_sum;
      res = '0;
      if (color_idx == 2'd0)
         color_acc = {24'd0, b};
      else
         color_acc = color_acc | ({24'd0, b} << (8 * color_idx));
      color_idx = color_idx + 2'd1;
      if (color_idx != 2'd0 && {1'b0, color_idx} < pix_bytes)
         return 1'b0;
      color_idx = '0;

      // bytes arrive blue, green, red, then alpha
      remaining = 32'(row_pos) * 32'(img_w) + (32'(img_w) - 32'(col_pos));
      span = pkt_run ? 32'(pkt_left) : 32'd1;
      if (span > remaining)
         span = remaining;
      res.kind = KIND_PIXEL;
      res.blue = color_acc[7:0];
      res.green = color_acc[15:8];
      res.red = color_acc[23:16];
      res.alpha = (pix_bytes == 3'd4) ? color_acc[31:24] : ALPHA_OPAQUE;
      res.start_row = row_pos;
      res.start_column = col_pos;
      res.run_length = span[7:0];
      res.image_width = img_w;
      res.image_height = img_h;
      res.image_done = (span == remaining);
      if (res.image_done) begin
         phase = PH_IDLE;
         return 1'b1;
      end
      // a run may wrap over several rows
      col_sum = 32'(col_pos) + span;
      col_pos = 16'(col_sum % 32'(img_w));
      row_pos = row_pos - 16'(col_sum / 32'(img_w));
      if (rle_mode) begin
         if (pkt_run) begin
            phase = PH_PACKET;
         end else begin
            pkt_left = pkt_left - 8'd1;
            if (pkt_left == 8'd0)
               phase = PH_PACKET;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                      output rsp_item_type res);
      res = '0;
      if (fs) begin
         phase = PH_HEADER;
         hdr_idx = '0;
      end
      case (phase)
         PH_HEADER: return header_step(b, res);
         PH_IDSKIP: begin
            id_left = id_left - 8'd1;
            if (id_left == 8'd0)
               start_image();
            return 1'b0;
         end
         PH_PACKET: begin
            pkt_left = 8'd1 + (b & PKT_COUNT_MASK);
            pkt_run = b[7];
            color_idx = '0;
            phase = PH_PIXEL;
            return 1'b0;
         end
         PH_PIXEL: return pixel_step(b, res);
         default: return 1'b0;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         clear_decoder();
         decoded_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (decode_byte(req_tdata, req_tuser[0], want))
               decoded_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.red = rsp_tdata[7:0];
            got.green = rsp_tdata[15:8];
            got.blue = rsp_tdata[23:16];
            got.alpha = rsp_tdata[31:24];
            got.start_row = rsp_tdata[47:32];
            got.start_column = rsp_tdata[63:48];
            got.run_length = rsp_tdata[71:64];
            got.image_width = rsp_tdata[87:72];
            got.image_height = rsp_tdata[103:88];
            got.image_done = rsp_tlast;
            if (decoded_q.size() == 0) begin
               $error("result transfer with nothing expected, kind %0d", got.kind);
               failures++;
            end else begin
               want = decoded_q.pop_front();
               check_field("result_kind", 32'(want.kind), 32'(got.kind));
               check_field("red", 32'(want.red), 32'(got.red));
               check_field("green", 32'(want.green), 32'(got.green));
               check_field("blue", 32'(want.blue), 32'(got.blue));
               check_field("alpha", 32'(want.alpha), 32'(got.alpha));
               check_field("start_row", 32'(want.start_row), 32'(got.start_row));
               check_field("start_column", 32'(want.start_column),
                           32'(got.start_column));
               check_field("run_length", 32'(want.run_length), 32'(got.run_length));
               check_field("image_width", 32'(want.image_width), 32'(got.image_width));
               check_field("image_height", 32'(want.image_height),
                           32'(got.image_height));
               check_field("image_done", 32'(want.image_done), 32'(got.image_done));
            end
         end
      end
      pending = decoded_q.size();
   end

endmodule

// ===== sim/tb_tga_rle_rgba_decoder.sv =====
`timescale 1ns / 1ps

module tb_tga_rle_rgba_decoder;
   import tgad_pkg::*;

   localparam int TOTAL_BYTES  = 1550;
   localparam int IDLE_LIMIT   = 2000;
   localparam int WHOLE_FILE   = 32'h7fffffff;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = '0;
   logic [0:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;

   int unsigned   pending_results;
   int            failures;

   int            idle_cycles = 0;
   int            burst_left = 0;
   int            gap_mode = 0;
   int            file_left = 0;
   logic          first_fs = 1'b0;
   int            bytes_sent = 0;

   int            stall_left = 0;
   int            ready_mode = 0;
   int            mode_left = 0;

   always #4 clock = ~clock;

   tga_rle_rgba_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tga_decode_checker decode_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .pending    (pending_results),
      .failures   (failures)
   );

   // receiver back-pressure, in a randomly picked mode: always ready, random ready, or stall bursts
   always @(negedge clock) begin
      logic take;
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      take = 1'b1;
      if (stall_left > 0) begin
         stall_left--;
         take = 1'b0;
      end else if (ready_mode == 1) begin
         take = ($urandom_range(0, 3) != 0);
      end else if (ready_mode == 2) begin
         if ($urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 12);
      end
      rsp_tready <= take;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // called and returns on a falling edge
   task automatic put_byte(input logic [7:0] b, input logic fs);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         case (gap_mode)
            0: gap = 0;
            1: gap = $urandom_range(0, 3);
            default: gap = $urandom_range(0, 15);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      wait (pending_results == 0);
      @(negedge clock);
   endtask

   // one file byte, dropped once the file has been cut short
   task automatic emit(input logic [7:0] b);
      if (file_left != 0) begin
         put_byte(b, first_fs);
         first_fs = 1'b0;
         file_left--;
      end
   endtask

   task automatic send_pixel(input int bpp);
      repeat (bpp) emit(8'($urandom));
   endtask

   task automatic send_file(input logic fs, input logic [7:0] id_len, input logic [7:0] cmap,
                            input logic [7:0] img_type, input logic [7:0] depth,
                            input logic [15:0] w, input logic [15:0] h,
                            input int max_bytes, input int trailing);
      logic [7:0]  hdr [18];
      logic [31:0] px_left;
      int          bpp;
      int          n;
      file_left = max_bytes;
      first_fs = fs;
      gap_mode = $urandom_range(0, 2);
      foreach (hdr[i]) hdr[i] = 8'($urandom);
      hdr[HDR_ID_LEN] = id_len;
      hdr[HDR_CMAP] = cmap;
      hdr[HDR_TYPE] = img_type;
      hdr[HDR_WIDTH_LO] = w[7:0];
      hdr[HDR_WIDTH_HI] = w[15:8];
      hdr[HDR_HEIGHT_LO] = h[7:0];
      hdr[HDR_HEIGHT_HI] = h[15:8];
      hdr[HDR_DEPTH] = depth;
      foreach (hdr[i]) emit(hdr[i]);
      if ((img_type == TYPE_RAW || img_type == TYPE_RLE) && cmap == 8'd0 &&
          (depth == DEPTH_24 || depth == DEPTH_32) && w != 16'd0 && h != 16'd0) begin
         repeat (id_len) emit(8'($urandom));
         px_left = 32'(w) * 32'(h);
         bpp = (depth == DEPTH_32) ? 4 : 3;
         while (px_left != 0 && file_left != 0) begin
            n = 1;
            if (img_type == TYPE_RLE) begin
               // run packets are not trimmed, so the last one is often clipped
               n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 128 : 16);
               if ($urandom_range(0, 1) == 1) begin
                  emit(8'h80 | 8'(n - 1));
                  send_pixel(bpp);
               end else begin
                  if (n > px_left)
                     n = px_left;
                  emit(8'(n - 1));
                  repeat (n) send_pixel(bpp);
               end
            end else begin
               send_pixel(bpp);
            end
            px_left = (n >= px_left) ? 32'd0 : px_left - n;
         end
      end
      repeat (trailing) put_byte(8'($urandom), 1'b0);
   endtask

   task automatic send_bad_header();
      logic [7:0]  id_len;
      logic [7:0]  cmap;
      logic [7:0]  img_type;
      logic [7:0]  depth;
      logic [15:0] w;
      logic [15:0] h;
      id_len = 8'($urandom_range(0, 3));
      cmap = 8'd0;
      img_type = $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW;
      depth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
      w = 16'($urandom_range(1, 4));
      h = 16'($urandom_range(1, 4));
      case ($urandom_range(0, 3))
         0: begin
            img_type = 8'($urandom);
            if (img_type == TYPE_RAW || img_type == TYPE_RLE)
               img_type = img_type + 8'd1;
            cmap = 8'($urandom);
            depth = 8'($urandom);
         end
         1: cmap = 8'($urandom_range(1, 255));
         2: begin
            depth = 8'($urandom);
            if (depth == DEPTH_24 || depth == DEPTH_32)
               depth = depth - 8'd8;
         end
         default: begin
            w = 16'($urandom);
            h = 16'($urandom);
            if ($urandom_range(0, 1) == 1)
               w = '0;
            else
               h = '0;
         end
      endcase
      send_file(1'b1, id_len, cmap, img_type, depth, w, h, WHOLE_FILE, $urandom_range(0, 3));
   endtask

   initial begin
      int pick;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // first file without file_start: parsed from the reset state
      send_file(1'b0, 8'd2, 8'd0, TYPE_RAW, DEPTH_24, 16'd3, 16'd2, WHOLE_FILE, 2);
      send_file(1'b1, 8'd0, 8'd0, 8'd0, DEPTH_24, 16'd4, 16'd4, WHOLE_FILE, 3);
      send_file(1'b1, 8'd0, 8'd0, 8'hff, DEPTH_32, 16'd1, 16'd1, WHOLE_FILE, 0);
      send_file(1'b1, 8'd0, 8'd1, TYPE_RAW, DEPTH_24, 16'd2, 16'd2, WHOLE_FILE, 2);
      send_file(1'b1, 8'd0, 8'd0, TYPE_RLE, 8'd16, 16'd2, 16'd2, WHOLE_FILE, 0);
      send_file(1'b1, 8'd0, 8'd0, TYPE_RAW, DEPTH_32, 16'd0, 16'd5, WHOLE_FILE, 2);
      send_file(1'b1, 8'd3, 8'd0, TYPE_RLE, DEPTH_24, 16'd4, 16'd0, WHOLE_FILE, 0);
      send_file(1'b1, 8'd0, 8'd0, TYPE_RAW, DEPTH_32, 16'd2, 16'd2, WHOLE_FILE, 0);
      send_file(1'b1, 8'd255, 8'd0, TYPE_RLE, DEPTH_32, 16'd1, 16'd1, WHOLE_FILE, 1);
      send_file(1'b1, 8'd0, 8'd0, TYPE_RLE, DEPTH_24, 16'd5, 16'd3, WHOLE_FILE, 1);
      wait_idle();
      // largest images, abandoned by the next file_start
      send_file(1'b1, 8'd0, 8'd0, TYPE_RAW, DEPTH_24, 16'hffff, 16'hffff, 40, 0);
      send_file(1'b1, 8'd1, 8'd0, TYPE_RLE, DEPTH_32, 16'hffff, 16'd2, 60, 0);
      // header cut short
      send_file(1'b1, 8'd0, 8'd0, TYPE_RAW, DEPTH_24, 16'd2, 16'd2, 10, 0);
      send_file(1'b1, 8'd0, 8'd0, TYPE_RLE, DEPTH_32, 16'd1, 16'd1, WHOLE_FILE, 0);

      while (bytes_sent < TOTAL_BYTES) begin
         if ($urandom_range(0, 5) == 0)
            wait_idle();
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_file(1'b1, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 6)) : 8'd0,
                      8'd0, $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW,
                      $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24,
                      16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                      WHOLE_FILE, $urandom_range(0, 2));
         end else if (pick < 80) begin
            // wide rows so that long runs wrap
            send_file(1'b1, 8'd0, 8'd0, TYPE_RLE, $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24,
                      16'($urandom_range(60, 300)), 16'($urandom_range(1, 2)),
                      WHOLE_FILE, 0);
         end else if (pick < 90) begin
            send_bad_header();
         end else if (pick < 96) begin
            send_file(1'b1, 8'($urandom_range(0, 2)), 8'd0,
                      $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW,
                      $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24,
                      16'($urandom), 16'($urandom), $urandom_range(1, 70), 0);
         end else begin
            // loose bytes, possibly continuing whatever state the parser is in
            file_left = $urandom_range(5, 30);
            first_fs = 1'($urandom_range(0, 1));
            while (file_left != 0) emit(8'($urandom));
         end
      end

      req_tvalid <= 1'b0;
      wait (pending_results == 0);
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tgad_pkg.sv
rtl/tgad_div.sv
rtl/tgad_parser.sv
rtl/tga_rle_rgba_decoder.sv
sim/tga_decode_checker.sv
sim/tb_tga_rle_rgba_decoder.sv
